// File: hdl/sk128_pkg.sv
// Shared constants and round functions for the SKINNY-128 block cipher pipeline.
// No dependencies; used by skinny128_block_cipher_top, sk128_scoreboard and the testbench.
package sk128_pkg;

  localparam int unsigned Rounds256 = 48;
  localparam int unsigned BlockW    = 128;
  localparam int unsigned WordW     = 64;
  localparam int unsigned CfgIdxW   = 3;

  typedef logic [7:0] byte_tbl_t [256];
  typedef logic [3:0] idx_tbl_t [16];

  typedef enum logic [CfgIdxW-1:0] {
    REG_TK1_LOW    = 3'd0,
    REG_TK1_HIGH   = 3'd1,
    REG_TK2_LOW    = 3'd2,
    REG_TK2_HIGH   = 3'd3,
    REG_TK3_LOW    = 3'd4,
    REG_TK3_HIGH   = 3'd5,
    REG_KEY_VARIANT = 3'd6
  } cfg_reg_e;

  localparam logic CMD_DECRYPT = 1'b1;

  localparam byte_tbl_t SBOX = '{
    8'h65, 8'h4c, 8'h6a, 8'h42, 8'h4b, 8'h63, 8'h43, 8'h6b, 8'h55, 8'h75, 8'h5a, 8'h7a,
    8'h53, 8'h73, 8'h5b, 8'h7b, 8'h35, 8'h8c, 8'h3a, 8'h81, 8'h89, 8'h33, 8'h80, 8'h3b,
    8'h95, 8'h25, 8'h98, 8'h2a, 8'h90, 8'h23, 8'h99, 8'h2b, 8'he5, 8'hcc, 8'he8, 8'hc1,
    8'hc9, 8'he0, 8'hc0, 8'he9, 8'hd5, 8'hf5, 8'hd8, 8'hf8, 8'hd0, 8'hf0, 8'hd9, 8'hf9,
    8'ha5, 8'h1c, 8'ha8, 8'h12, 8'h1b, 8'ha0, 8'h13, 8'ha9, 8'h05, 8'hb5, 8'h0a, 8'hb8,
    8'h03, 8'hb0, 8'h0b, 8'hb9, 8'h32, 8'h88, 8'h3c, 8'h85, 8'h8d, 8'h34, 8'h84, 8'h3d,
    8'h91, 8'h22, 8'h9c, 8'h2c, 8'h94, 8'h24, 8'h9d, 8'h2d, 8'h62, 8'h4a, 8'h6c, 8'h45,
    8'h4d, 8'h64, 8'h44, 8'h6d, 8'h52, 8'h72, 8'h5c, 8'h7c, 8'h54, 8'h74, 8'h5d, 8'h7d,
    8'ha1, 8'h1a, 8'hac, 8'h15, 8'h1d, 8'ha4, 8'h14, 8'had, 8'h02, 8'hb1, 8'h0c, 8'hbc,
    8'h04, 8'hb4, 8'h0d, 8'hbd, 8'he1, 8'hc8, 8'hec, 8'hc5, 8'hcd, 8'he4, 8'hc4, 8'hed,
    8'hd1, 8'hf1, 8'hdc, 8'hfc, 8'hd4, 8'hf4, 8'hdd, 8'hfd, 8'h36, 8'h8e, 8'h38, 8'h82,
    8'h8b, 8'h30, 8'h83, 8'h39, 8'h96, 8'h26, 8'h9a, 8'h28, 8'h93, 8'h20, 8'h9b, 8'h29,
    8'h66, 8'h4e, 8'h68, 8'h41, 8'h49, 8'h60, 8'h40, 8'h69, 8'h56, 8'h76, 8'h58, 8'h78,
    8'h50, 8'h70, 8'h59, 8'h79, 8'ha6, 8'h1e, 8'haa, 8'h11, 8'h19, 8'ha3, 8'h10, 8'hab,
    8'h06, 8'hb6, 8'h08, 8'hba, 8'h00, 8'hb3, 8'h09, 8'hbb, 8'he6, 8'hce, 8'hea, 8'hc2,
    8'hcb, 8'he3, 8'hc3, 8'heb, 8'hd6, 8'hf6, 8'hda, 8'hfa, 8'hd3, 8'hf3, 8'hdb, 8'hfb,
    8'h31, 8'h8a, 8'h3e, 8'h86, 8'h8f, 8'h37, 8'h87, 8'h3f, 8'h92, 8'h21, 8'h9e, 8'h2e,
    8'h97, 8'h27, 8'h9f, 8'h2f, 8'h61, 8'h48, 8'h6e, 8'h46, 8'h4f, 8'h67, 8'h47, 8'h6f,
    8'h51, 8'h71, 8'h5e, 8'h7e, 8'h57, 8'h77, 8'h5f, 8'h7f, 8'ha2, 8'h18, 8'hae, 8'h16,
    8'h1f, 8'ha7, 8'h17, 8'haf, 8'h01, 8'hb2, 8'h0e, 8'hbe, 8'h07, 8'hb7, 8'h0f, 8'hbf,
    8'he2, 8'hca, 8'hee, 8'hc6, 8'hcf, 8'he7, 8'hc7, 8'hef, 8'hd2, 8'hf2, 8'hde, 8'hfe,
    8'hd7, 8'hf7, 8'hdf, 8'hff
  };

  function automatic byte_tbl_t make_inv_sbox();
    byte_tbl_t inv;
    for (int i = 0; i < 256; i++) begin
      inv[SBOX[i]] = 8'(i);
    end
    return inv;
  endfunction

  localparam byte_tbl_t INV_SBOX = make_inv_sbox();

  // New cell i takes old cell SHR_SRC[i] (ShiftRows) or PT_SRC[i] (tweakey permutation).
  localparam idx_tbl_t SHR_SRC = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd7, 4'd4, 4'd5, 4'd6,
    4'd10, 4'd11, 4'd8, 4'd9, 4'd13, 4'd14, 4'd15, 4'd12
  };
  localparam idx_tbl_t PT_SRC = '{
    4'd9, 4'd15, 4'd8, 4'd13, 4'd10, 4'd14, 4'd12, 4'd11,
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7
  };

  // Round constant of round r, evaluated at elaboration.
  function automatic logic [5:0] rc_at(int r);
    logic [5:0] rc;
    rc = 6'd0;
    for (int i = 0; i <= r; i++) begin
      rc = {rc[4:0], 1'b0} ^ {5'd0, rc[5] ^ rc[4] ^ 1'b1};
    end
    return rc;
  endfunction

  function automatic logic [7:0] lfsr2(logic [7:0] x);
    return {x[6:0], x[7] ^ x[5]};
  endfunction

  function automatic logic [7:0] lfsr3(logic [7:0] x);
    return {x[0] ^ x[6], x[7:1]};
  endfunction

  function automatic logic [BlockW-1:0] pt_perm(logic [BlockW-1:0] tk);
    logic [BlockW-1:0] t;
    for (int i = 0; i < 16; i++) begin
      t[8*i +: 8] = tk[8*PT_SRC[i] +: 8];
    end
    return t;
  endfunction

  function automatic logic [BlockW-1:0] tk2_next(logic [BlockW-1:0] tk);
    logic [BlockW-1:0] t;
    t = pt_perm(tk);
    for (int i = 0; i < 8; i++) begin
      t[8*i +: 8] = lfsr2(t[8*i +: 8]);
    end
    return t;
  endfunction

  function automatic logic [BlockW-1:0] tk3_next(logic [BlockW-1:0] tk);
    logic [BlockW-1:0] t;
    t = pt_perm(tk);
    for (int i = 0; i < 8; i++) begin
      t[8*i +: 8] = lfsr3(t[8*i +: 8]);
    end
    return t;
  endfunction

  function automatic logic [BlockW-1:0] enc_round(logic [BlockW-1:0] s,
                                                  logic [WordW-1:0] rk,
                                                  logic [5:0] rc);
    logic [BlockW-1:0] b;
    logic [BlockW-1:0] t;
    for (int i = 0; i < 16; i++) begin
      b[8*i +: 8] = SBOX[s[8*i +: 8]];
    end
    b[7:0]   = b[7:0] ^ {4'd0, rc[3:0]};
    b[39:32] = b[39:32] ^ {6'd0, rc[5:4]};
    b[71:64] = b[71:64] ^ 8'h02;
    b[63:0]  = b[63:0] ^ rk;
    for (int i = 0; i < 16; i++) begin
      t[8*i +: 8] = b[8*SHR_SRC[i] +: 8];
    end
    for (int c = 0; c < 4; c++) begin
      b[8*c +: 8]      = t[8*c +: 8] ^ t[8*(8+c) +: 8] ^ t[8*(12+c) +: 8];
      b[8*(4+c) +: 8]  = t[8*c +: 8];
      b[8*(8+c) +: 8]  = t[8*(4+c) +: 8] ^ t[8*(8+c) +: 8];
      b[8*(12+c) +: 8] = t[8*c +: 8] ^ t[8*(8+c) +: 8];
    end
    return b;
  endfunction

  function automatic logic [BlockW-1:0] dec_round(logic [BlockW-1:0] s,
                                                  logic [WordW-1:0] rk,
                                                  logic [5:0] rc);
    logic [BlockW-1:0] b;
    logic [BlockW-1:0] t;
    for (int c = 0; c < 4; c++) begin
      b[8*c +: 8]      = s[8*(4+c) +: 8];
      b[8*(8+c) +: 8]  = s[8*(12+c) +: 8] ^ s[8*(4+c) +: 8];
      b[8*(4+c) +: 8]  = s[8*(8+c) +: 8] ^ s[8*(12+c) +: 8] ^ s[8*(4+c) +: 8];
      b[8*(12+c) +: 8] = s[8*c +: 8] ^ s[8*(12+c) +: 8];
    end
    for (int i = 0; i < 16; i++) begin
      t[8*SHR_SRC[i] +: 8] = b[8*i +: 8];
    end
    t[63:0]  = t[63:0] ^ rk;
    t[7:0]   = t[7:0] ^ {4'd0, rc[3:0]};
    t[39:32] = t[39:32] ^ {6'd0, rc[5:4]};
    t[71:64] = t[71:64] ^ 8'h02;
    for (int i = 0; i < 16; i++) begin
      b[8*i +: 8] = INV_SBOX[t[8*i +: 8]];
    end
    return b;
  endfunction

endpackage

// File: hdl/skinny128_block_cipher_top.sv
// Stage 0 registers an accepted request and each round stage has its own register;
// done_o and the result come from the last stage. One round per stage.
// Throughput: one request per cycle while busy_o is low; each round has its own stage.
// In 256-bit mode the last MAX_ROUNDS - 48 stages pass the block through unchanged.
// Reset clears the valid bits and the tweakey registers (key_variant to 1); busy_o is
// high for the first cycle after reset and low from then on. The receiver cannot stall.
module skinny128_block_cipher_top #(
  parameter int unsigned MAX_ROUNDS = 56
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        command_i,
  input  logic [63:0] block_low_i,
  input  logic [63:0] block_high_i,
  output logic        done_o,
  output logic [63:0] result_low_o,
  output logic [63:0] result_high_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  localparam int unsigned RSmall = (sk128_pkg::Rounds256 < MAX_ROUNDS) ?
                                   sk128_pkg::Rounds256 : MAX_ROUNDS;

  logic [63:0] tk1_low_q, tk1_high_q, tk2_low_q, tk2_high_q, tk3_low_q, tk3_high_q;
  logic        key_variant_q;
  logic        busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tk1_low_q     <= '0;
      tk1_high_q    <= '0;
      tk2_low_q     <= '0;
      tk2_high_q    <= '0;
      tk3_low_q     <= '0;
      tk3_high_q    <= '0;
      key_variant_q <= 1'b1;
      busy_q        <= 1'b1;
    end else begin
      busy_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sk128_pkg::REG_TK1_LOW:     tk1_low_q     <= cfg_wdata_i;
          sk128_pkg::REG_TK1_HIGH:    tk1_high_q    <= cfg_wdata_i;
          sk128_pkg::REG_TK2_LOW:     tk2_low_q     <= cfg_wdata_i;
          sk128_pkg::REG_TK2_HIGH:    tk2_high_q    <= cfg_wdata_i;
          sk128_pkg::REG_TK3_LOW:     tk3_low_q     <= cfg_wdata_i;
          sk128_pkg::REG_TK3_HIGH:    tk3_high_q    <= cfg_wdata_i;
          sk128_pkg::REG_KEY_VARIANT: key_variant_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  assign busy_o = busy_q;

  // Tweakey schedule: the round keys are a fixed linear function of the registers.
  logic [127:0] tk1_w [MAX_ROUNDS];
  logic [127:0] tk2_w [MAX_ROUNDS];
  logic [127:0] tk3_w [MAX_ROUNDS];
  logic [63:0]  rk_w  [MAX_ROUNDS];

  assign tk1_w[0] = {tk1_high_q, tk1_low_q};
  assign tk2_w[0] = {tk2_high_q, tk2_low_q};
  assign tk3_w[0] = {tk3_high_q, tk3_low_q};

  for (genvar r = 0; r < MAX_ROUNDS; r++) begin : g_ks
    assign rk_w[r] = tk1_w[r][63:0] ^ tk2_w[r][63:0] ^
                     (key_variant_q ? tk3_w[r][63:0] : 64'd0);
    if (r + 1 < MAX_ROUNDS) begin : g_next
      assign tk1_w[r+1] = sk128_pkg::pt_perm(tk1_w[r]);
      assign tk2_w[r+1] = sk128_pkg::tk2_next(tk2_w[r]);
      assign tk3_w[r+1] = sk128_pkg::tk3_next(tk3_w[r]);
    end
  end

  // Stage 0 holds the accepted request; stage j+1 holds the block after round stage j.
  logic         vld_q [MAX_ROUNDS+1];
  logic         cmd_q [MAX_ROUNDS+1];
  logic [127:0] st_q  [MAX_ROUNDS+1];
  logic [127:0] st_d  [MAX_ROUNDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= MAX_ROUNDS; j++) begin
        vld_q[j] <= 1'b0;
      end
    end else begin
      vld_q[0] <= start_i && !busy_q;
      for (int j = 0; j < MAX_ROUNDS; j++) begin
        vld_q[j+1] <= vld_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      cmd_q[0] <= command_i;
      st_q[0]  <= {block_high_i, block_low_i};
    end
    for (int j = 0; j < MAX_ROUNDS; j++) begin
      if (vld_q[j]) begin
        cmd_q[j+1] <= cmd_q[j];
        st_q[j+1]  <= st_d[j];
      end
    end
  end

  for (genvar j = 0; j < MAX_ROUNDS; j++) begin : g_rnd
    localparam int unsigned KBig = MAX_ROUNDS - 1 - j;
    localparam logic [5:0]  RcEnc = sk128_pkg::rc_at(j);
    localparam logic [5:0]  RcBig = sk128_pkg::rc_at(KBig);
    if (j < RSmall) begin : g_both
      // Decryption walks the rounds backward, so the key index depends on the mode.
      localparam int unsigned KSmall = RSmall - 1 - j;
      localparam logic [5:0]  RcSmall = sk128_pkg::rc_at(KSmall);
      always_comb begin
        if (cmd_q[j] != sk128_pkg::CMD_DECRYPT) begin
          st_d[j] = sk128_pkg::enc_round(st_q[j], rk_w[j], RcEnc);
        end else if (key_variant_q) begin
          st_d[j] = sk128_pkg::dec_round(st_q[j], rk_w[KBig], RcBig);
        end else begin
          st_d[j] = sk128_pkg::dec_round(st_q[j], rk_w[KSmall], RcSmall);
        end
      end
    end else begin : g_big
      always_comb begin
        if (!key_variant_q) begin
          st_d[j] = st_q[j];
        end else if (cmd_q[j] != sk128_pkg::CMD_DECRYPT) begin
          st_d[j] = sk128_pkg::enc_round(st_q[j], rk_w[j], RcEnc);
        end else begin
          st_d[j] = sk128_pkg::dec_round(st_q[j], rk_w[KBig], RcBig);
        end
      end
    end
  end

  assign done_o        = vld_q[MAX_ROUNDS];
  assign result_low_o  = st_q[MAX_ROUNDS][63:0];
  assign result_high_o = st_q[MAX_ROUNDS][127:64];

endmodule

// File: hdl/sk128_checker.sv
// Port-level checker for skinny128_block_cipher_top, attached by the bind below.
// Depends on the top level's port list only.
module sk128_checker #(
  parameter int unsigned MAX_ROUNDS = 56
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        command_i,
  input logic [63:0] block_low_i,
  input logic [63:0] block_high_i,
  input logic        done_o,
  input logic [63:0] result_low_o,
  input logic [63:0] result_high_o,
  input logic        cfg_we_i,
  input logic [2:0]  cfg_idx_i,
  input logic [63:0] cfg_wdata_i
);

  localparam int unsigned Lat = MAX_ROUNDS + 1;

  // Every result comes from a request accepted exactly the pipeline depth earlier.
  a_done_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Lat))
    else $error("result without a matching request");

  // Once busy_o has fallen after reset, it never rises again, so no later request is refused.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && $past(!busy_o) |-> !busy_o)
    else $error("busy raised after reset");

  // Nothing leaves the pipeline in the first cycle after reset.
  a_busy_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !done_o)
    else $error("result during reset exit");

endmodule

bind skinny128_block_cipher_top sk128_checker #(.MAX_ROUNDS(MAX_ROUNDS)) u_sk128_checker (.*);

// File: test/sk128_checker.sv
`timescale 1ns / 100ps
// Checker for the SKINNY-128 cipher pipeline: tracks tweakey writes, predicts each result.
// Depends on sk128_pkg for the register indexes, the decrypt code, the S-box and the cell tables.
module sk128_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        command_i,
  input  logic [63:0] block_low_i,
  input  logic [63:0] block_high_i,
  input  logic        done_i,
  input  logic [63:0] result_low_i,
  input  logic [63:0] result_high_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o
);

  logic [63:0]  tk_words [6];
  logic         big_key;
  logic [127:0] expected_blocks [$];
  logic [7:0]   unsbox [256];

  initial begin
    for (int i = 0; i < 256; i++) unsbox[sk128_pkg::SBOX[i]] = 8'(i);
  end

  function automatic logic [127:0] cipher_block(logic cmd, logic [63:0] lo, logic [63:0] hi);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] k1 [16];
    logic [7:0] k2 [16];
    logic [7:0] k3 [16];
    logic [7:0] rkey [56][8];
    logic [5:0] rcon [56];
    logic [5:0] rc;
    logic [127:0] res;
    logic [7:0] a0, a1, a2, a3;
    int nr;
    nr = big_key ? 56 : 48;
    rc = '0;
    for (int i = 0; i < 8; i++) begin
      s[i] = lo[8*i +: 8];
      s[8+i] = hi[8*i +: 8];
      k1[i] = tk_words[0][8*i +: 8];
      k1[8+i] = tk_words[1][8*i +: 8];
      k2[i] = tk_words[2][8*i +: 8];
      k2[8+i] = tk_words[3][8*i +: 8];
      k3[i] = tk_words[4][8*i +: 8];
      k3[8+i] = tk_words[5][8*i +: 8];
    end
    for (int r = 0; r < nr; r++) begin
      rc = {rc[4:0], 1'b0} ^ {5'd0, rc[5] ^ rc[4] ^ 1'b1};
      rcon[r] = rc;
      for (int i = 0; i < 8; i++) rkey[r][i] = k1[i] ^ k2[i] ^ (big_key ? k3[i] : 8'h00);
      // Tweakey schedule: cell permutation, then the LFSRs on rows 0 and 1.
      for (int i = 0; i < 16; i++) t[i] = k1[sk128_pkg::PT_SRC[i]];
      k1 = t;
      for (int i = 0; i < 16; i++) t[i] = k2[sk128_pkg::PT_SRC[i]];
      k2 = t;
      for (int i = 0; i < 16; i++) t[i] = k3[sk128_pkg::PT_SRC[i]];
      k3 = t;
      for (int i = 0; i < 8; i++) begin
        k2[i] = {k2[i][6:0], k2[i][7] ^ k2[i][5]};
        k3[i] = {k3[i][0] ^ k3[i][6], k3[i][7:1]};
      end
    end
    if (cmd != sk128_pkg::CMD_DECRYPT) begin
      for (int r = 0; r < nr; r++) begin
        for (int i = 0; i < 16; i++) s[i] = sk128_pkg::SBOX[s[i]];
        s[0] ^= {4'd0, rcon[r][3:0]};
        s[4] ^= {6'd0, rcon[r][5:4]};
        s[8] ^= 8'h02;
        for (int i = 0; i < 8; i++) s[i] ^= rkey[r][i];
        for (int i = 0; i < 16; i++) t[i] = s[sk128_pkg::SHR_SRC[i]];
        for (int c = 0; c < 4; c++) begin
          a0 = t[c]; a1 = t[4+c]; a2 = t[8+c]; a3 = t[12+c];
          s[c] = a0 ^ a2 ^ a3;
          s[4+c] = a0;
          s[8+c] = a1 ^ a2;
          s[12+c] = a0 ^ a2;
        end
      end
    end else begin
      for (int r = nr - 1; r >= 0; r--) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[c]; a1 = s[4+c]; a2 = s[8+c]; a3 = s[12+c];
          t[c] = a1;
          t[8+c] = a3 ^ a1;
          t[4+c] = a2 ^ a3 ^ a1;
          t[12+c] = a0 ^ a3;
        end
        for (int i = 0; i < 16; i++) s[sk128_pkg::SHR_SRC[i]] = t[i];
        for (int i = 0; i < 8; i++) s[i] ^= rkey[r][i];
        s[0] ^= {4'd0, rcon[r][3:0]};
        s[4] ^= {6'd0, rcon[r][5:4]};
        s[8] ^= 8'h02;
        for (int i = 0; i < 16; i++) s[i] = unsbox[s[i]];
      end
    end
    for (int i = 0; i < 16; i++) res[8*i +: 8] = s[i];
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [127:0] want;
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) tk_words[i] <= '0;
      big_key <= 1'b1;
      fail_count_o <= 0;
      expected_blocks.delete();
      pending_o <= 0;
    end else begin
      // A request is predicted with the tweakey that held before this edge.
      if (start_i && !busy_i) begin
        expected_blocks.push_back(cipher_block(command_i, block_low_i, block_high_i));
      end
      if (done_i) begin
        if (expected_blocks.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %h_%h", result_high_i, result_low_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_blocks.pop_front();
          if (want[63:0] !== result_low_i || want[127:64] !== result_high_i) begin
            if (fail_count_o < 10) begin
              $display("mismatch: low exp %h got %h, high exp %h got %h",
                       want[63:0], result_low_i, want[127:64], result_high_i);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= expected_blocks.size();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sk128_pkg::REG_TK1_LOW:     tk_words[0] <= cfg_wdata_i;
          sk128_pkg::REG_TK1_HIGH:    tk_words[1] <= cfg_wdata_i;
          sk128_pkg::REG_TK2_LOW:     tk_words[2] <= cfg_wdata_i;
          sk128_pkg::REG_TK2_HIGH:    tk_words[3] <= cfg_wdata_i;
          sk128_pkg::REG_TK3_LOW:     tk_words[4] <= cfg_wdata_i;
          sk128_pkg::REG_TK3_HIGH:    tk_words[5] <= cfg_wdata_i;
          sk128_pkg::REG_KEY_VARIANT: big_key <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end
endmodule

// File: test/tb_skinny128_block_cipher_top.sv
`timescale 1ns / 100ps
// Testbench top: drives tweakey settings and cipher requests into the pipeline.
// Depends on sk128_pkg, skinny128_block_cipher_top and sk128_scoreboard.
module tb_skinny128_block_cipher_top;

  localparam logic [2:0] CfgIdxUnused = 3'd7;
  localparam logic CmdEncrypt = ~sk128_pkg::CMD_DECRYPT;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        command_i = 1'b0;
  logic [63:0] block_low_i = '0;
  logic [63:0] block_high_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_wdata_i = '0;
  logic        busy_o, done_o;
  logic [63:0] result_low_o, result_high_o;
  int          fail_count, pending;
  bit          steady;

  skinny128_block_cipher_top uut (.*);

  sk128_scoreboard checker_i (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .command_i, .block_low_i, .block_high_i,
    .done_i(done_o), .result_low_i(result_low_o), .result_high_i(result_high_o),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Issues one request and returns on the edge that accepts it.
  task automatic send_request(logic cmd, logic [63:0] lo, logic [63:0] hi);
    if (!steady && $urandom_range(99) < 13) begin
      start_i <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    command_i <= cmd;
    block_low_i <= lo;
    block_high_i <= hi;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_tweakey(logic [63:0] k [6], logic variant);
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
    write_reg(sk128_pkg::REG_TK1_LOW, k[0]);
    write_reg(sk128_pkg::REG_TK1_HIGH, k[1]);
    write_reg(sk128_pkg::REG_TK2_LOW, k[2]);
    write_reg(sk128_pkg::REG_TK2_HIGH, k[3]);
    write_reg(sk128_pkg::REG_TK3_LOW, k[4]);
    write_reg(sk128_pkg::REG_TK3_HIGH, k[5]);
    write_reg(sk128_pkg::REG_KEY_VARIANT, {63'd0, variant});
    write_reg(CfgIdxUnused, rand_word());
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_requests(int n);
    for (int i = 0; i < n; i++) begin
      send_request(1'($urandom), rand_word(), rand_word());
    end
  endtask

  initial begin
    logic [63:0] k [6];
    steady = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (busy_o);

    // Reset tweakey (all zero, 384-bit): extreme blocks and single set bits.
    send_request(CmdEncrypt, '0, '0);
    send_request(sk128_pkg::CMD_DECRYPT, '0, '0);
    send_request(CmdEncrypt, '1, '1);
    send_request(sk128_pkg::CMD_DECRYPT, '1, '1);
    for (int b = 0; b < 64; b += 9) begin
      send_request(1'(b), 64'd1 << b, 64'd1 << (63 - b));
    end
    random_requests(120);

    // All-ones tweakey in 256-bit mode; the third word must not matter.
    for (int i = 0; i < 6; i++) k[i] = '1;
    load_tweakey(k, 1'b0);
    send_request(CmdEncrypt, '0, '1);
    send_request(sk128_pkg::CMD_DECRYPT, '1, '0);
    random_requests(120);

    for (int i = 0; i < 6; i++) k[i] = rand_word();
    load_tweakey(k, 1'b1);
    steady = 1'b1;
    random_requests(160);
    steady = 1'b0;

    for (int i = 0; i < 6; i++) k[i] = rand_word();
    load_tweakey(k, 1'b0);
    random_requests(160);

    for (int i = 0; i < 6; i++) k[i] = '1;
    load_tweakey(k, 1'b1);
    random_requests(120);

    for (int i = 0; i < 6; i++) k[i] = rand_word();
    load_tweakey(k, 1'b1);
    random_requests(100);

    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// File: filelist.f
hdl/sk128_pkg.sv
hdl/skinny128_block_cipher_top.sv
hdl/sk128_checker.sv
test/sk128_checker.sv
test/tb_skinny128_block_cipher_top.sv
